// ===== rtl/urng_pkg.sv =====
// ----------------------------------------------------------------------------
// urng_pkg
// Shared types and constants for the ultrasonic trigger and echo ranger.
// ----------------------------------------------------------------------------
package urng_pkg;

  // Event codes carried by the opcode field
  typedef enum logic [1:0] {
    OP_SLOW = 2'd0,
    OP_FAST = 2'd1,
    OP_ECHO = 2'd2
  } urng_op_e;

  // Register indexes on the configuration port
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_TRIGLEN = 1'b1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int ECHO_TIMER_BITS_DEF = 16;
  localparam int PERIOD_W            = 16;
  localparam int TRIGLEN_W           = 8;
  localparam int TRIG_CNT_W          = TRIGLEN_W + 1;
  localparam int DIST_W              = 14;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd600;
  localparam logic [TRIGLEN_W-1:0] TRIGLEN_RESET = 8'd5;

  // distance = floor(width*10/58) = floor(width*5/29).
  // Widths at or above SatWidth give a distance above the 14-bit range,
  // so only 17 width bits ever reach the multiplier.
  localparam int WIDTH_W   = 17;
  localparam int SatWidth  = 95028;
  localparam int RECIP_K   = 24;
  localparam int RECIP_W   = 22;
  // 5 * ceil(2^24 / 29); exact for every 5*width below 2^24 / 9
  localparam logic [RECIP_W-1:0] RECIP_MUL = 22'd2892625;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

  // Result of the state update stage, handed to the distance stage
  typedef struct packed {
    logic               trig;
    logic               done;
    logic               sat;
    logic [WIDTH_W-1:0] width;
  } urng_meas_t;

endpackage

// ===== rtl/urng_regs.sv =====
// ----------------------------------------------------------------------------
// urng_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module urng_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urng_pkg::ADDR_W-1:0]    paddr,
  input  logic [urng_pkg::DATA_W-1:0]    pwdata,
  output logic [urng_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [urng_pkg::PERIOD_W-1:0]  period_ticks_o,
  output logic [urng_pkg::TRIGLEN_W-1:0] trigger_len_o
);
  import urng_pkg::*;

  logic                 wr_en;
  logic [PERIOD_W-1:0]  period_q;
  logic [TRIGLEN_W-1:0] trig_len_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write, decoded on the word index only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      trig_len_q <= TRIGLEN_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PERIOD:  period_q   <= pwdata[PERIOD_W-1:0];
        REG_TRIGLEN: trig_len_q <= pwdata[TRIGLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[2])
      REG_PERIOD:  prdata = DATA_W'(period_q);
      REG_TRIGLEN: prdata = DATA_W'(trig_len_q);
      default:     prdata = '0;
    endcase
  end

  assign period_ticks_o = period_q;
  assign trigger_len_o  = trig_len_q;

endmodule

// ===== rtl/urng_core.sv =====
// ----------------------------------------------------------------------------
// urng_core
// Period, trigger and echo timing state, updated once per event transfer.
// ----------------------------------------------------------------------------
module urng_core #(
  parameter int ECHO_TIMER_BITS = urng_pkg::ECHO_TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [1:0]                    opcode_i,
  input  logic                          echo_level_i,
  input  logic [urng_pkg::PERIOD_W-1:0]  period_ticks_i,
  input  logic [urng_pkg::TRIGLEN_W-1:0] trigger_len_i,
  output urng_pkg::urng_meas_t           meas_o
);
  import urng_pkg::*;

  localparam int TW    = ECHO_TIMER_BITS;
  localparam int WideW = (TW > WIDTH_W) ? TW : WIDTH_W;

  logic [PERIOD_W-1:0]   period_cnt_q, period_cnt_d, period_dec;
  logic [TRIG_CNT_W-1:0] trig_cnt_q, trig_cnt_d, trig_dec;
  logic                  trig_lvl_q, trig_lvl_d;
  logic [TW-1:0]         timer_q, timer_d;
  logic [TW-1:0]         stamp_q, stamp_d;
  logic                  phase_q, phase_d;
  logic                  done;
  logic [TW-1:0]         width;
  logic [WideW-1:0]      width_ext;
  urng_meas_t            meas_q;

  assign period_dec = (period_cnt_q != '0) ? period_cnt_q - 1'b1 : period_cnt_q;
  assign trig_dec   = trig_cnt_q - 1'b1;
  assign width      = timer_q - stamp_q;

  // Next state for one event
  always_comb begin
    period_cnt_d = period_cnt_q;
    trig_cnt_d   = trig_cnt_q;
    trig_lvl_d   = trig_lvl_q;
    timer_d      = timer_q;
    stamp_d      = stamp_q;
    phase_d      = phase_q;
    done         = 1'b0;
    case (urng_op_e'(opcode_i))
      OP_SLOW: begin
        period_cnt_d = period_dec;
        if (period_dec == '0) begin
          period_cnt_d = period_ticks_i;
          trig_cnt_d   = TRIG_CNT_W'(trigger_len_i) + 1'b1;
        end
      end
      OP_FAST: begin
        // counter stops at zero
        if (trig_cnt_q != '0) begin
          trig_cnt_d = trig_dec;
          if (trig_dec == TRIG_CNT_W'(trigger_len_i)) trig_lvl_d = 1'b1;
          if (trig_dec == '0) trig_lvl_d = 1'b0;
        end
        timer_d = timer_q + 1'b1;
      end
      OP_ECHO: begin
        if (echo_level_i && !phase_q) begin
          stamp_d = timer_q;
          phase_d = 1'b1;
        end else if (!echo_level_i && phase_q) begin
          phase_d = 1'b0;
          timer_d = '0;
          done    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_cnt_q <= PERIOD_RESET;
      trig_cnt_q   <= '0;
      trig_lvl_q   <= 1'b0;
      timer_q      <= '0;
      stamp_q      <= '0;
      phase_q      <= 1'b0;
    end else if (load_i) begin
      period_cnt_q <= period_cnt_d;
      trig_cnt_q   <= trig_cnt_d;
      trig_lvl_q   <= trig_lvl_d;
      timer_q      <= timer_d;
      stamp_q      <= stamp_d;
      phase_q      <= phase_d;
    end
  end

  // Pulse width, clipped to what the distance stage needs
  assign width_ext = WideW'(width);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      meas_q.trig  <= trig_lvl_d;
      meas_q.done  <= done;
      meas_q.sat   <= (width_ext >= WideW'(SatWidth));
      meas_q.width <= width_ext[WIDTH_W-1:0];
    end
  end

  assign meas_o = meas_q;

endmodule

// ===== rtl/urng_dist.sv =====
// ----------------------------------------------------------------------------
// urng_dist
// Width to centimetre conversion and the result register.
// ----------------------------------------------------------------------------
module urng_dist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  urng_pkg::urng_meas_t        meas_i,
  output logic                       trigger_out_o,
  output logic [urng_pkg::DIST_W-1:0] distance_cm_o,
  output logic                       distance_valid_o
);
  import urng_pkg::*;

  logic [WIDTH_W+RECIP_W-1:0] prod;
  logic [DIST_W-1:0]          dist_new;
  logic [DIST_W-1:0]          dist_last_q;
  logic [DIST_W-1:0]          dist_sel;
  logic                       trig_q;
  logic [DIST_W-1:0]          dist_q;
  logic                       done_q;

  // floor(width*5/29) by reciprocal multiply
  assign prod     = meas_i.width * RECIP_MUL;
  assign dist_new = meas_i.sat ? DIST_MAX : prod[RECIP_K +: DIST_W];
  assign dist_sel = meas_i.done ? dist_new : dist_last_q;

  // Last completed distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_last_q <= '0;
    end else if (load_i && meas_i.done) begin
      dist_last_q <= dist_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      trig_q <= meas_i.trig;
      dist_q <= dist_sel;
      done_q <= meas_i.done;
    end
  end

  assign trigger_out_o    = trig_q;
  assign distance_cm_o    = dist_q;
  assign distance_valid_o = done_q;

endmodule

// ===== rtl/ultrasonic_trigger_and_echo_ranger_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_trigger_and_echo_ranger_top
// Event-driven ultrasonic ranging controller with APB configuration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one event per transfer:
//   a slow tick, a fast tick or an echo edge with its pin level.
//   Output channel (out_valid_o / out_ready_i) returns one result per event:
//   trigger line level, last distance and a flag for a fresh distance.
//   Three register stages: input register, state update, distance convert
//   (the reciprocal multiply). Throughput is one event per cycle while
//   out_ready_i stays high.
//   Each stage holds its item until the next stage frees up, so the block
//   keeps taking events while results wait; once all three stages are full
//   and out_ready_i stays low, in_ready_o drops.
//   Reset clears the trigger counter, echo timer, last distance, pipeline;
//   period counter and register go to 600, trigger length to 5. The user
//   must write registers only while the block holds no events (unchecked).
// ----------------------------------------------------------------------------
module ultrasonic_trigger_and_echo_ranger_top #(
  parameter int ECHO_TIMER_BITS = urng_pkg::ECHO_TIMER_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [urng_pkg::ADDR_W-1:0] paddr,
  input  logic [urng_pkg::DATA_W-1:0] pwdata,
  output logic [urng_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // event channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic                       echo_level_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       trigger_out_o,
  output logic [urng_pkg::DIST_W-1:0] distance_cm_o,
  output logic                       distance_valid_o
);
  import urng_pkg::*;

  logic [PERIOD_W-1:0]  period_ticks;
  logic [TRIGLEN_W-1:0] trigger_len;
  logic                 a_valid_q, b_valid_q, c_valid_q;
  logic                 a_ready, b_ready, c_ready;
  logic [1:0]           a_opcode_q;
  logic                 a_level_q;
  urng_meas_t           meas;

  urng_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .period_ticks_o (period_ticks),
    .trigger_len_o  (trigger_len)
  );

  // Stage ready chain: a stage moves when it is empty or its item moves on
  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_opcode_q <= opcode_i;
      a_level_q  <= echo_level_i;
    end
  end

  urng_core #(
    .ECHO_TIMER_BITS (ECHO_TIMER_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (a_valid_q && b_ready),
    .opcode_i       (a_opcode_q),
    .echo_level_i   (a_level_q),
    .period_ticks_i (period_ticks),
    .trigger_len_i  (trigger_len),
    .meas_o         (meas)
  );

  urng_dist u_dist (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (b_valid_q && c_ready),
    .meas_i           (meas),
    .trigger_out_o    (trigger_out_o),
    .distance_cm_o    (distance_cm_o),
    .distance_valid_o (distance_valid_o)
  );

  assign out_valid_o = c_valid_q;

  // Back-pressure only ever comes from a held input item
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_valid_q)
    else $error("input stalled with empty input register");

  // An input transfer always lands in the input register
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> a_valid_q)
    else $error("input transfer lost");

  // A blocked item in the input register is kept
  a_in_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_ready) |=> a_valid_q)
    else $error("stalled item dropped");

endmodule

// ===== verif/ultrasonic_ranger_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_ranger_checker
// Watches the register port and both event channels of the ranger, keeps a
// cycle-free model of its counters, echo timer and distance, and compares
// every result transfer with the oldest predicted reading.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_checker
  import urng_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // register port, observed only
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  // event channel
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          opcode_i,
  input  logic                echo_level_i,
  // result channel
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                trigger_out_i,
  input  logic [DIST_W-1:0]   distance_cm_i,
  input  logic                distance_valid_i,
  // status for the stimulus side
  output int unsigned         readings_due_o,
  output int unsigned         mismatch_cnt_o
);

  localparam int TIMER_W = ECHO_TIMER_BITS_DEF;

  typedef struct packed {
    logic              trig;
    logic [DIST_W-1:0] dist_cm;
    logic              fresh;
  } reading_t;

  // register copies
  logic [PERIOD_W-1:0]   period_cfg;
  logic [TRIGLEN_W-1:0]  trig_len_cfg;

  // ranger state
  logic [PERIOD_W-1:0]   period_cnt;
  logic [TRIG_CNT_W-1:0] trig_cnt;
  logic                  trig_lvl;
  logic [TIMER_W-1:0]    echo_timer;
  logic [TIMER_W-1:0]    echo_stamp;
  logic                  echo_open;
  logic [DIST_W-1:0]     last_dist;

  reading_t    expected_readings[$];
  int unsigned mismatches;

  assign mismatch_cnt_o = mismatches;

  // Advance the ranger by one event and return the reading it produces
  task automatic step_ranger(input logic [1:0] op, input logic lvl, output reading_t res);
    logic [TIMER_W-1:0] width;
    int unsigned        dist_val;
    res.fresh = 1'b0;
    case (op)
      OP_SLOW: begin
        if (period_cnt != '0) period_cnt--;
        if (period_cnt == '0) begin
          period_cnt = period_cfg;
          trig_cnt   = {1'b0, trig_len_cfg} + 1'b1;
        end
      end
      OP_FAST: begin
        // counter parks at zero; the zero check wins over the raise
        if (trig_cnt != '0) begin
          trig_cnt--;
          if (trig_cnt == {1'b0, trig_len_cfg}) trig_lvl = 1'b1;
          if (trig_cnt == '0) trig_lvl = 1'b0;
        end
        echo_timer++;
      end
      OP_ECHO: begin
        // edges that do not match the open/closed phase are dropped
        if (lvl && !echo_open) begin
          echo_stamp = echo_timer;
          echo_open  = 1'b1;
        end else if (!lvl && echo_open) begin
          width    = echo_timer - echo_stamp;
          dist_val = (32'(width) * 10) / 58;
          if (dist_val > 32'(DIST_MAX)) dist_val = 32'(DIST_MAX);
          last_dist  = dist_val[DIST_W-1:0];
          echo_open  = 1'b0;
          echo_timer = '0;
          res.fresh  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.trig    = trig_lvl;
    res.dist_cm = last_dist;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reading_t want;
    reading_t got;
    if (!rst_ni) begin
      period_cfg   <= PERIOD_RESET;
      trig_len_cfg <= TRIGLEN_RESET;
      period_cnt   <= PERIOD_RESET;
      trig_cnt     <= '0;
      trig_lvl     <= 1'b0;
      echo_timer   <= '0;
      echo_stamp   <= '0;
      echo_open    <= 1'b0;
      last_dist    <= '0;
      mismatches   <= 0;
      expected_readings.delete();
      readings_due_o <= 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        if (paddr[ADDR_W-1:2] == REG_PERIOD) period_cfg = pwdata[PERIOD_W-1:0];
        else if (paddr[ADDR_W-1:2] == REG_TRIGLEN) trig_len_cfg = pwdata[TRIGLEN_W-1:0];
      end

      // event transfer
      if (in_valid_i && in_ready_i) begin
        step_ranger(opcode_i, echo_level_i, want);
        expected_readings.push_back(want);
      end

      // result transfer
      if (out_valid_i && out_ready_i) begin
        got = '{trig: trigger_out_i, dist_cm: distance_cm_i, fresh: distance_valid_i};
        if (expected_readings.size() == 0) begin
          $error("result transfer with no reading pending");
          mismatches = mismatches + 1;
        end else begin
          want = expected_readings.pop_front();
          if (got.trig !== want.trig) begin
            $error("trigger_out: expected %0d, got %0d", want.trig, got.trig);
            mismatches = mismatches + 1;
          end
          if (got.dist_cm !== want.dist_cm) begin
            $error("distance_cm: expected %0d, got %0d", want.dist_cm, got.dist_cm);
            mismatches = mismatches + 1;
          end
          if (got.fresh !== want.fresh) begin
            $error("distance_valid: expected %0d, got %0d", want.fresh, got.fresh);
            mismatches = mismatches + 1;
          end
        end
      end
      readings_due_o <= expected_readings.size();
    end
  end

endmodule

// ===== verif/ultrasonic_trigger_and_echo_ranger_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_trigger_and_echo_ranger_top_test
// Drives tick and echo-edge events into the ranger under several period and
// trigger-length settings, with random gaps and stalls on both channels;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ultrasonic_trigger_and_echo_ranger_top_test;
  import urng_pkg::*;

  localparam logic [1:0] OP_NONE      = 2'd3;  // opcode with no meaning
  localparam int         DRAIN_CYCLES = 6;
  localparam int         HOLD_CYCLES  = 60;

  logic                clk;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          opcode_i;
  logic                echo_level_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                trigger_out_o;
  logic [DIST_W-1:0]   distance_cm_o;
  logic                distance_valid_o;

  int unsigned         readings_due;
  int unsigned         mismatch_cnt;
  int unsigned         sent_items;

  ultrasonic_trigger_and_echo_ranger_top uut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .echo_level_i     (echo_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .trigger_out_o    (trigger_out_o),
    .distance_cm_o    (distance_cm_o),
    .distance_valid_o (distance_valid_o)
  );

  ultrasonic_ranger_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .echo_level_i     (echo_level_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .trigger_out_i    (trigger_out_o),
    .distance_cm_i    (distance_cm_o),
    .distance_valid_i (distance_valid_o),
    .readings_due_o   (readings_due),
    .mismatch_cnt_o   (mismatch_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // window in which neither side idles
  function automatic bit calm_stretch();
    return sent_items >= 1150 && sent_items < 1350;
  endfunction

  // One event transfer; entered and left at a falling edge
  task automatic send_event(input logic [1:0] op, input logic lvl);
    if (!calm_stretch()) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid_i <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    echo_level_i <= lvl;
    do @(posedge clk); while (!in_ready_o);
    sent_items++;
    @(negedge clk);
  endtask

  // Stop offering events until every reading has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (readings_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_noise();
    send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  // Trigger burst, then an echo pulse of random length
  task automatic send_measurement();
    int n;
    repeat ($urandom_range(0, 3)) send_event(OP_SLOW, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 6)) send_event(OP_FAST, 1'($urandom_range(0, 1)));
    send_event(OP_ECHO, 1'b1);
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 300);
    repeat (n) begin
      send_event(($urandom_range(0, 99) < 85) ? OP_FAST : OP_SLOW, 1'($urandom_range(0, 1)));
    end
    send_event(OP_ECHO, 1'b0);
  endtask

  task automatic run_setting(input logic [PERIOD_W-1:0] period, input logic [TRIGLEN_W-1:0] len,
                             input int unsigned count);
    int unsigned stop_at;
    write_reg(REG_PERIOD, DATA_W'(period));
    write_reg(REG_TRIGLEN, DATA_W'(len));
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 99) < 70) send_measurement();
      else send_noise();
    end
    wait_drained();
  endtask

  // Receiver: random stalls, one long hold-off once traffic is under way
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sent_items >= 800) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready_i <= calm_stretch() ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end
  end

  // Stimulus
  initial begin
    int unsigned stop_at;
    sent_items   = 0;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    opcode_i     <= OP_SLOW;
    echo_level_i <= 1'b0;
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // directed: every opcode with both levels, edges out of phase, short pulses
    send_event(OP_SLOW, 1'b0);
    send_event(OP_SLOW, 1'b1);
    send_event(OP_FAST, 1'b0);
    send_event(OP_FAST, 1'b1);
    send_event(OP_NONE, 1'b0);
    send_event(OP_NONE, 1'b1);
    send_event(OP_ECHO, 1'b0);   // falling while closed: dropped
    send_event(OP_ECHO, 1'b1);
    send_event(OP_ECHO, 1'b1);   // rising while open: dropped
    repeat (3) send_event(OP_FAST, 1'b1);
    send_event(OP_NONE, 1'b1);
    send_event(OP_ECHO, 1'b0);
    send_event(OP_ECHO, 1'b1);   // zero-width pulse
    send_event(OP_ECHO, 1'b0);
    send_event(OP_ECHO, 1'b1);
    repeat (6) send_event(OP_FAST, 1'b0);
    send_event(OP_ECHO, 1'b0);
    wait_drained();

    // run the reset period down so later settings get reloaded
    write_reg(REG_PERIOD, DATA_W'(1));
    write_reg(REG_TRIGLEN, DATA_W'(2));
    stop_at = sent_items + 640;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 99) < 95) send_event(OP_SLOW, 1'($urandom_range(0, 1)));
      else send_noise();
    end
    wait_drained();

    // settings sweep; the longest period goes last since it never reloads again
    run_setting(16'd4, 8'd255, 220);
    run_setting(16'd0, 8'd0, 220);
    run_setting(16'd3, 8'd1, 200);
    run_setting(16'd9, 8'd12, 180);
    run_setting(16'hFFFF, 8'd7, 170);

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/urng_pkg.sv
rtl/urng_regs.sv
rtl/urng_core.sv
rtl/urng_dist.sv
rtl/ultrasonic_trigger_and_echo_ranger_top.sv
verif/ultrasonic_ranger_checker.sv
verif/ultrasonic_trigger_and_echo_ranger_top_test.sv
